/* design/twmis_pkg.sv */
// Shared widths, operation codes and limits for the tree independent-set solver.
package twmis_pkg;

	localparam int MAX_NODES_DEF = 16;

	localparam int OP_W     = 2;
	localparam int IDX_W    = 4;
	localparam int WEIGHT_W = 32;
	localparam int NC_W     = 5;
	localparam int BEST_W   = 35;

	localparam logic [NC_W-1:0]   NODE_COUNT_RESET = NC_W'(16);
	localparam logic [BEST_W-1:0] BEST_MAX         = '1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_EDGE  = 2'd1,
		OP_SOLVE = 2'd2
	} op_t;

endpackage

/* design/twmis_store.sv */
// Weight and neighbor-mask memories with per-entry valid bits and registered reads.
module twmis_store #(
	parameter int MAX_NODES = twmis_pkg::MAX_NODES_DEF,
	localparam int ADDR_W = $clog2(MAX_NODES)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ADDR_W-1:0]                rd_addr,
	input  logic                             w_we,
	input  logic [ADDR_W-1:0]                w_addr,
	input  logic [twmis_pkg::WEIGHT_W-1:0]   w_data,
	input  logic                             m_we,
	input  logic [ADDR_W-1:0]                m_addr,
	input  logic [MAX_NODES-1:0]             m_data,
	input  logic                             m_clear,
	output logic [twmis_pkg::WEIGHT_W-1:0]   rd_weight,
	output logic [MAX_NODES-1:0]             rd_mask
);
	import twmis_pkg::*;

	logic [WEIGHT_W-1:0]  wmem [MAX_NODES];
	logic [MAX_NODES-1:0] mmem [MAX_NODES];

	logic [MAX_NODES-1:0] wvalid_q;
	logic [MAX_NODES-1:0] mvalid_q;
	logic                 wv_q;
	logic                 mv_q;
	logic [WEIGHT_W-1:0]  wrd_q;
	logic [MAX_NODES-1:0] mrd_q;

	// Entries never written since reset (or, for masks, since the last clear)
	// read as zero through their valid bits.
	always_ff @(posedge clk) begin
		if (w_we)
			wmem[w_addr] <= w_data;
		if (m_we)
			mmem[m_addr] <= m_data;
		wrd_q <= wmem[rd_addr];
		mrd_q <= mmem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			mvalid_q <= '0;
			wv_q     <= 1'b0;
			mv_q     <= 1'b0;
		end else begin
			if (w_we)
				wvalid_q[w_addr] <= 1'b1;
			if (m_clear)
				mvalid_q <= '0;
			else if (m_we)
				mvalid_q[m_addr] <= 1'b1;
			wv_q <= wvalid_q[rd_addr];
			mv_q <= mvalid_q[rd_addr];
		end
	end

	assign rd_weight = wv_q ? wrd_q : '0;
	assign rd_mask   = mv_q ? mrd_q : '0;

endmodule

/* design/twmis_search.sv */
// Gray-code subset walk: one subset per cycle, running sum, conflict count and best sum.
module twmis_search #(
	parameter int MAX_NODES = twmis_pkg::MAX_NODES_DEF,
	localparam int ADDR_W = $clog2(MAX_NODES),
	localparam int NCNT_W = $clog2(MAX_NODES + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [NCNT_W-1:0]              n,
	output logic [ADDR_W-1:0]              rd_addr,
	input  logic signed [twmis_pkg::WEIGHT_W-1:0] rd_weight,
	input  logic [MAX_NODES-1:0]           rd_mask,
	output logic                           done,
	output logic [twmis_pkg::BEST_W-1:0]   best_sum
);
	import twmis_pkg::*;

	localparam int CW     = MAX_NODES + 1;
	localparam int SUM_W  = WEIGHT_W + $clog2(MAX_NODES);
	localparam int CMP_W  = (SUM_W > BEST_W + 1) ? SUM_W : BEST_W + 1;
	localparam int CONF_W = $clog2(MAX_NODES * MAX_NODES + 1);
	localparam int PC_W   = $clog2(MAX_NODES + 1);

	logic [CW-1:0]           cnt_q;
	logic                    run_q;
	logic                    busy_q;
	logic                    v_s1;
	logic                    v_s2;
	logic [ADDR_W-1:0]       idx_s1;
	logic [MAX_NODES-1:0]    set_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CONF_W-1:0]       conf_q;
	logic signed [SUM_W-1:0] best_q;

	logic [CW-1:0]           last_cnt;
	logic [ADDR_W-1:0]       flip_idx;
	logic                    adding;
	logic [PC_W-1:0]         pc;
	logic signed [SUM_W-1:0] w_ext;
	logic signed [CMP_W-1:0] best_ext;
	logic signed [CMP_W-1:0] lim_ext;

	// Step k of the Gray sequence toggles the node at the lowest set bit of k.
	always_comb begin
		flip_idx = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (cnt_q[i])
				flip_idx = ADDR_W'(i);
		end
	end

	assign last_cnt = (CW'(1) << n) - CW'(1);
	assign rd_addr  = flip_idx;

	// The neighbor mask never holds the node itself, so the overlap with the
	// set before the toggle counts the edges gained or lost.
	assign adding = !set_q[idx_s1];
	assign pc     = PC_W'($countones(rd_mask & set_q));
	assign w_ext  = SUM_W'(rd_weight);

	assign done = busy_q && !run_q && !v_s1 && !v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			busy_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			set_q  <= '0;
			sum_q  <= '0;
			conf_q <= '0;
			best_q <= '0;
		end else if (start) begin
			cnt_q  <= CW'(1);
			run_q  <= (n != '0);
			busy_q <= 1'b1;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			set_q  <= '0;
			sum_q  <= '0;
			conf_q <= '0;
			best_q <= '0;
		end else begin
			v_s1 <= run_q;
			v_s2 <= v_s1;
			if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == last_cnt)
					run_q <= 1'b0;
			end
			if (v_s1) begin
				set_q[idx_s1] <= adding;
				if (adding) begin
					sum_q  <= sum_q + w_ext;
					conf_q <= conf_q + CONF_W'(pc);
				end else begin
					sum_q  <= sum_q - w_ext;
					conf_q <= conf_q - CONF_W'(pc);
				end
			end
			if (v_s2 && conf_q == '0 && sum_q > best_q)
				best_q <= sum_q;
			if (done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= flip_idx;
	end

	assign best_ext = CMP_W'(best_q);
	assign lim_ext  = CMP_W'(BEST_MAX);
	assign best_sum = (best_ext > lim_ext) ? BEST_MAX : best_ext[BEST_W-1:0];

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (32'(idx_s1) < 32'(n)))
		else $error("toggled node lies outside the searched range");

	a_best_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		best_q >= 0)
		else $error("best sum fell below the empty set");

	a_empty_no_conf: assert property (@(posedge clk) disable iff (!arst_n)
		(set_q == '0) |-> (conf_q == '0))
		else $error("conflict count nonzero for the empty set");

endmodule

/* design/tree_max_weight_independent_set.sv */
// Maximum-weight independent set solver: control sequencer, handshakes and result register.
// Load weight: accepted every cycle while idle, one memory write. Add edge: read-modify-write
// of both neighbor masks through the single read port. Solve: walks the subsets of the n
// searched nodes, one subset per cycle; the result is registered once the search is done and
// the output slot is free. Reset clears all valid bits at once, so weights and masks read as
// zero right after reset and node_count returns to 16; no clearing pass.
module tree_max_weight_independent_set #(
	parameter int MAX_NODES = twmis_pkg::MAX_NODES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [twmis_pkg::NC_W-1:0]           node_count,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [twmis_pkg::OP_W-1:0]           operation,
	input  logic [twmis_pkg::IDX_W-1:0]          node_index,
	input  logic [twmis_pkg::IDX_W-1:0]          other_node,
	input  logic signed [twmis_pkg::WEIGHT_W-1:0] weight,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [twmis_pkg::BEST_W-1:0]         best_sum
);
	import twmis_pkg::*;

	localparam int ADDR_W = $clog2(MAX_NODES);
	localparam int NCNT_W = $clog2(MAX_NODES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_SOLVE,
		ST_WAIT
	} state_t;

	state_t               state_q;
	logic [NC_W-1:0]      nc_q;
	logic [ADDR_W-1:0]    a_q;
	logic [ADDR_W-1:0]    b_q;
	logic                 out_valid_q;
	logic [BEST_W-1:0]    best_q;

	logic                 accept;
	logic                 idx_ok;
	logic                 edge_ok;
	logic                 slot_free;
	logic                 res_load;
	logic [NCNT_W-1:0]    n_eff;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    srch_addr;
	logic                 w_we;
	logic                 m_we;
	logic [ADDR_W-1:0]    m_addr;
	logic [MAX_NODES-1:0] m_data;
	logic                 m_clear;
	logic [WEIGHT_W-1:0]  rd_weight;
	logic [MAX_NODES-1:0] rd_mask;
	logic                 srch_start;
	logic                 srch_done;
	logic [BEST_W-1:0]    srch_best;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign res_load  = slot_free && ((state_q == ST_SOLVE && srch_done) || state_q == ST_WAIT);

	assign idx_ok  = (32'(node_index) < MAX_NODES);
	assign edge_ok = idx_ok && (32'(other_node) < MAX_NODES) && (node_index != other_node);

	assign n_eff = (32'(nc_q) > MAX_NODES) ? NCNT_W'(MAX_NODES) : NCNT_W'(nc_q);

	assign w_we       = accept && (op_t'(operation) == OP_LOAD) && idx_ok;
	assign srch_start = accept && (op_t'(operation) == OP_SOLVE);
	assign m_clear    = (state_q == ST_SOLVE) && srch_done;

	// Edge add reads mask[a], writes it back while reading mask[b], then writes mask[b].
	// The two ends differ, so writing mask[a] never meets the read of mask[b] in the same cycle.
	always_comb begin
		m_we   = 1'b0;
		m_addr = a_q;
		m_data = rd_mask;
		unique case (state_q)
			ST_EDGE_A: begin
				m_we   = 1'b1;
				m_addr = a_q;
				m_data = rd_mask | (MAX_NODES'(1) << b_q);
			end
			ST_EDGE_B: begin
				m_we   = 1'b1;
				m_addr = b_q;
				m_data = rd_mask | (MAX_NODES'(1) << a_q);
			end
			ST_IDLE, ST_SOLVE, ST_WAIT: begin
				m_we = 1'b0;
			end
			default: begin
				m_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		priority case (state_q)
			ST_SOLVE:  rd_addr = srch_addr;
			ST_EDGE_A: rd_addr = b_q;
			default:   rd_addr = ADDR_W'(node_index);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nc_q        <= NODE_COUNT_RESET;
			a_q         <= '0;
			b_q         <= '0;
			out_valid_q <= 1'b0;
			best_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				nc_q <= node_count;
			if (res_load) begin
				best_q      <= srch_best;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (operation)
							OP_EDGE: begin
								if (edge_ok) begin
									a_q     <= ADDR_W'(node_index);
									b_q     <= ADDR_W'(other_node);
									state_q <= ST_EDGE_A;
								end
							end
							OP_SOLVE: state_q <= ST_SOLVE;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_EDGE_A: state_q <= ST_EDGE_B;
				ST_EDGE_B: state_q <= ST_IDLE;
				ST_SOLVE: begin
					if (srch_done) begin
						if (slot_free)
							state_q <= ST_IDLE;
						else
							state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// The search unit holds its best sum until the next start.
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign best_sum  = best_q;

	twmis_store #(
		.MAX_NODES(MAX_NODES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.w_we     (w_we),
		.w_addr   (ADDR_W'(node_index)),
		.w_data   (weight),
		.m_we     (m_we),
		.m_addr   (m_addr),
		.m_data   (m_data),
		.m_clear  (m_clear),
		.rd_weight(rd_weight),
		.rd_mask  (rd_mask)
	);

	twmis_search #(
		.MAX_NODES(MAX_NODES)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (srch_start),
		.n        (n_eff),
		.rd_addr  (srch_addr),
		.rd_weight(rd_weight),
		.rd_mask  (rd_mask),
		.done     (srch_done),
		.best_sum (srch_best)
	);

	a_done_in_solve: assert property (@(posedge clk) disable iff (!arst_n)
		srch_done |-> (state_q == ST_SOLVE || state_q == ST_WAIT))
		else $error("search finished outside a solve");

	a_no_mask_write_in_solve: assert property (@(posedge clk) disable iff (!arst_n)
		m_we |-> (state_q != ST_SOLVE && state_q != ST_WAIT))
		else $error("mask write during a solve");

	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EDGE_A) |=> (state_q == ST_EDGE_B))
		else $error("edge update skipped its second write");

endmodule

/* dv/tree_max_weight_independent_set_tb.sv */
// Self-checking testbench for the tree maximum-weight independent set solver.
`timescale 1ns / 100ps

module tree_max_weight_independent_set_tb;
	import twmis_pkg::*;

	localparam int NODE_LIMIT = MAX_NODES_DEF;
	localparam longint SUM_CEILING = (64'sd1 <<< BEST_W) - 64'sd1;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_TOP = 32'h7FFFFFFF;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_BOTTOM = 32'h80000000;

	typedef struct packed {
		logic [OP_W-1:0]            op;
		logic [IDX_W-1:0]           a;
		logic [IDX_W-1:0]           b;
		logic signed [WEIGHT_W-1:0] w;
	} item_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [NC_W-1:0]            node_count;
	logic                       in_valid;
	logic                       in_stall;
	logic [OP_W-1:0]            operation;
	logic [IDX_W-1:0]           node_index;
	logic [IDX_W-1:0]           other_node;
	logic signed [WEIGHT_W-1:0] weight;
	logic                       out_valid;
	logic                       out_stall;
	logic [BEST_W-1:0]          best_sum;

	// Shadow copy of the solver state.
	logic signed [WEIGHT_W-1:0] node_wt [NODE_LIMIT];
	logic [NODE_LIMIT-1:0]      nbr_masks [NODE_LIMIT];
	logic [NC_W-1:0]            active_count;

	logic [BEST_W-1:0] expected_sums [$];
	logic [BEST_W-1:0] best_want;
	int                failures;
	int                items_accepted;
	bit                idle_on;
	int                hold_cycles;
	int                stall_left;

	tree_max_weight_independent_set u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.node_count (node_count),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.node_index (node_index),
		.other_node (other_node),
		.weight     (weight),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.best_sum   (best_sum)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Exhaustive search over every subset of the searched nodes.
	function automatic logic [BEST_W-1:0] best_independent_sum();
		int     n;
		longint best;
		longint total_w;
		bit     ok;
		n = (active_count > NODE_LIMIT) ? NODE_LIMIT : int'(active_count);
		best = 0;
		for (int s = 1; s < (1 << n); s++) begin
			total_w = 0;
			ok = 1'b1;
			for (int i = 0; i < n; i++) begin
				if (s[i]) begin
					if ((nbr_masks[i] & NODE_LIMIT'(s)) != '0) begin
						ok = 1'b0;
						break;
					end
					total_w += longint'(node_wt[i]);
				end
			end
			if (ok && total_w > best)
				best = total_w;
		end
		if (best > SUM_CEILING)
			best = SUM_CEILING;
		return best[BEST_W-1:0];
	endfunction

	function automatic void apply_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b, input logic signed [WEIGHT_W-1:0] w);
		case (op)
			OP_LOAD: node_wt[a] = w;
			OP_EDGE: begin
				if (a != b) begin
					nbr_masks[a][b] = 1'b1;
					nbr_masks[b][a] = 1'b1;
				end
			end
			OP_SOLVE: begin
				expected_sums.push_back(best_independent_sum());
				foreach (nbr_masks[i])
					nbr_masks[i] = '0;
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return WEIGHT_TOP;
			1: return WEIGHT_BOTTOM;
			2: return $urandom;
			3: return $urandom_range(0, 200) - 100;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	function automatic logic [NC_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		else if (r < 70)
			return NC_W'($urandom_range(1, 6));
		else if (r < 95)
			return NC_W'($urandom_range(7, 10));
		else if (r < 99)
			return NC_W'($urandom_range(11, 13));
		return NC_W'(NODE_LIMIT);
	endfunction

	// Leaves in_valid high after acceptance; a later call's idle gap or wait_idle takes it down.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b, input logic signed [WEIGHT_W-1:0] w);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		operation  <= op;
		node_index <= a;
		other_node <= b;
		weight     <= w;
		do @(posedge clk); while (in_stall);
		apply_item(op, a, b, w);
		if (op != OP_UNUSED)
			items_accepted++;
	endtask

	task automatic send_random_op(input int span);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			send_item(OP_LOAD, IDX_W'($urandom_range(0, span)), IDX_W'($urandom),
				pick_weight());
		else if (r < 7)
			send_item(OP_EDGE, IDX_W'($urandom_range(0, span)),
				IDX_W'($urandom_range(0, span)), $urandom);
		else if (r < 9)
			send_item(OP_SOLVE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
		else
			send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
	endtask

	// An edge add can still be in flight when the last result comes out, hence the tail.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_node_count(input logic [NC_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_valid  <= 1'b1;
		node_count <= v;
		do @(posedge clk); while (!cfg_ready);
		active_count = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_item(OP_SOLVE, 4'd0, 4'd0, '0);
	endtask

	task automatic test_directed_cases();
		set_node_count(5'd4);
		send_item(OP_LOAD, 4'd0, 4'd0, WEIGHT_TOP);
		send_item(OP_LOAD, 4'd1, 4'd0, WEIGHT_BOTTOM);
		send_item(OP_LOAD, 4'd2, 4'd0, WEIGHT_TOP);
		send_item(OP_LOAD, 4'd3, 4'd0, 32'sd5);
		send_item(OP_EDGE, 4'd0, 4'd2, '0);
		// A self edge must not exclude node 3.
		send_item(OP_EDGE, 4'd3, 4'd3, '0);
		send_item(OP_UNUSED, 4'd15, 4'd15, '1);
		// This edge reaches past the searched nodes and must not matter.
		send_item(OP_EDGE, 4'd1, 4'd15, '0);
		send_item(OP_SOLVE, 4'd0, 4'd0, '0);
		set_node_count('0);
		send_item(OP_SOLVE, 4'd0, 4'd0, '0);
	endtask

	task automatic test_full_graph();
		for (int i = 1; i < NODE_LIMIT; i++) begin
			if (i != 2)
				send_item(OP_LOAD, IDX_W'(i), 4'd0, WEIGHT_TOP);
		end
		set_node_count('1);
		send_item(OP_SOLVE, 4'd15, 4'd15, '1);
	endtask

	// Random trees with random labels and weights, some noise items, then a solve, at times two.
	task automatic test_random_trees(input int target);
		item_t batch [$];
		int    order [$];
		item_t it;
		int    nn;
		int    parent;
		bit    fresh;
		fresh = 1'b1;
		while (items_accepted < target) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if (fresh || $urandom_range(0, 2) != 0)
				set_node_count(pick_size());
			fresh = 1'b0;
			nn = (active_count > NODE_LIMIT) ? NODE_LIMIT : int'(active_count);
			batch.delete();
			order.delete();
			for (int i = 0; i < nn; i++)
				order.insert($urandom_range(0, order.size()), i);
			for (int i = 0; i < nn; i++) begin
				if ($urandom_range(0, 7) != 0) begin
					it.op = OP_LOAD;
					it.a  = IDX_W'(order[i]);
					it.b  = IDX_W'($urandom);
					it.w  = pick_weight();
					batch.insert($urandom_range(0, batch.size()), it);
				end
			end
			for (int i = 1; i < nn; i++) begin
				parent = $urandom_range(0, i - 1);
				it.op = OP_EDGE;
				it.a  = IDX_W'(order[i]);
				it.b  = IDX_W'(order[parent]);
				if ($urandom_range(0, 1)) begin
					it.a = IDX_W'(order[parent]);
					it.b = IDX_W'(order[i]);
				end
				it.w = $urandom;
				batch.insert($urandom_range(0, batch.size()), it);
			end
			repeat ($urandom_range(0, 2)) begin
				it.a = IDX_W'($urandom);
				it.b = IDX_W'($urandom);
				it.w = $urandom;
				case ($urandom_range(0, 2))
					0: it.op = OP_EDGE;
					1: begin
						it.op = OP_EDGE;
						it.b  = it.a;
					end
					default: it.op = OP_UNUSED;
				endcase
				batch.insert($urandom_range(0, batch.size()), it);
			end
			foreach (batch[i])
				send_item(batch[i].op, batch[i].a, batch[i].b, batch[i].w);
			send_item(OP_SOLVE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
			// A second solve sees the edges already cleared.
			if ($urandom_range(0, 4) == 0)
				send_item(OP_SOLVE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
		end
	endtask

	task automatic test_output_hold();
		set_node_count(5'd2);
		idle_on = 1'b0;
		hold_cycles = 300;
		repeat (40)
			send_random_op(3);
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_steady_stream();
		set_node_count(5'd3);
		idle_on = 1'b0;
		repeat (100)
			send_random_op(NODE_LIMIT - 1);
	endtask

	// Receiver: a long hold when asked, else short random stall bursts while idle_on is set.
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 5);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_sums.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%t: best_sum %0d arrived with none pending", $realtime, best_sum);
			end else begin
				best_want = expected_sums.pop_front();
				if (best_sum !== best_want) begin
					failures++;
					if (failures <= 10)
						$display("%t: best_sum expected %0d, got %0d", $realtime, best_want,
							best_sum);
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		node_count = NODE_COUNT_RESET;
		in_valid   = 1'b0;
		operation  = OP_LOAD;
		node_index = '0;
		other_node = '0;
		weight     = '0;
		foreach (node_wt[i]) begin
			node_wt[i]   = '0;
			nbr_masks[i] = '0;
		end
		active_count   = NODE_COUNT_RESET;
		failures       = 0;
		items_accepted = 0;
		idle_on        = 1'b1;
		hold_cycles    = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed_cases();
		test_full_graph();
		test_random_trees(1030);
		test_output_hold();
		test_steady_stream();

		wait_idle();
		repeat (20) @(posedge clk);
		if (failures == 0 && expected_sums.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* tree_max_weight_independent_set.f */
design/twmis_pkg.sv
design/twmis_store.sv
design/twmis_search.sv
design/tree_max_weight_independent_set.sv
dv/tree_max_weight_independent_set_tb.sv
